### rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

   // Result kinds carried on the response channel.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Header fields.
   localparam logic [7:0] OPCODE_MASK = 8'h0F;
   localparam logic [7:0] LENGTH_MASK = 8'h7F;
   localparam logic [6:0] LEN_EXT16   = 7'd126;
   localparam logic [6:0] LEN_EXT64   = 7'd127;
   localparam logic [3:0] OPC_TEXT    = 4'h1;
   localparam logic [3:0] OPC_CLOSE   = 4'h8;
   localparam logic [3:0] OPC_PING    = 4'h9;

   // Depth of the result queue between parser and response port.
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       last;
   } rsp_type;

endpackage

### rtl/wsd_if.sv
// Valid/ready channel interfaces for received bytes and deframed results.
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       restart;

   modport source (output valid, output rx_byte, output restart, input ready);
   modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic [3:0] frame_opcode;
   logic       last;

   modport source (output valid, output kind, output payload_byte, output frame_opcode,
                   output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input frame_opcode,
                   input last, output ready);
endinterface

### rtl/wsd_parser.sv
// Front end: frame phase machine that classifies each byte and pushes results.
module wsd_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [7:0]      in_byte,
   input  logic            in_restart,
   output logic            in_ready,
   input  logic            space_ok,
   output logic            push_valid,
   output wsd_pkg::rsp_type push_data
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_EXT_HI  = 3'd2,
      PH_EXT_LO  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_HALTED  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [15:0] remain_ff, remain_in;
   logic [7:0]  len_high_ff, len_high_in;

   logic        accept;
   logic [6:0]  len7;
   logic [15:0] len16;
   logic [15:0] remain_dec;
   phase_type   frame_end_phase;

   assign in_ready = space_ok;
   assign accept   = in_valid && space_ok;
   assign len7     = 7'(in_byte & wsd_pkg::LENGTH_MASK);
   assign len16    = {len_high_ff, in_byte};
   assign remain_dec = (remain_ff != 16'd0) ? remain_ff - 16'd1 : remain_ff;
   assign frame_end_phase = (opcode_ff == wsd_pkg::OPC_CLOSE) ? PH_HALTED : PH_HEADER;

   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      remain_in   = remain_ff;
      len_high_in = len_high_ff;
      push_valid  = 1'b0;
      push_data.kind         = wsd_pkg::KIND_PAYLOAD;
      push_data.payload_byte = 8'd0;
      push_data.frame_opcode = opcode_ff;
      push_data.last         = 1'b1;
      if (accept) begin
         if (in_restart) begin
            phase_in    = PH_HEADER;
            opcode_in   = 4'd0;
            remain_in   = 16'd0;
            len_high_in = 8'd0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  opcode_in = 4'(in_byte & wsd_pkg::OPCODE_MASK);
                  phase_in  = PH_LENGTH;
               end
               PH_LENGTH: begin
                  if (len7 == wsd_pkg::LEN_EXT16) begin
                     phase_in = PH_EXT_HI;
                  end else if (len7 == wsd_pkg::LEN_EXT64) begin
                     push_valid     = 1'b1;
                     push_data.kind = wsd_pkg::KIND_ERROR;
                     phase_in       = PH_HALTED;
                  end else if (len7 == 7'd0) begin
                     push_valid     = 1'b1;
                     push_data.kind = wsd_pkg::KIND_EMPTY;
                     remain_in      = 16'd0;
                     phase_in       = frame_end_phase;
                  end else begin
                     remain_in = {9'd0, len7};
                     phase_in  = PH_PAYLOAD;
                  end
               end
               PH_EXT_HI: begin
                  len_high_in = in_byte;
                  phase_in    = PH_EXT_LO;
               end
               PH_EXT_LO: begin
                  // A zero extended length still closes out the frame as empty.
                  if (len16 == 16'd0) begin
                     push_valid     = 1'b1;
                     push_data.kind = wsd_pkg::KIND_EMPTY;
                     remain_in      = 16'd0;
                     phase_in       = frame_end_phase;
                  end else begin
                     remain_in = len16;
                     phase_in  = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  push_valid             = 1'b1;
                  push_data.payload_byte = in_byte;
                  remain_in              = remain_dec;
                  push_data.last         = (remain_dec == 16'd0);
                  if (remain_dec == 16'd0) begin
                     phase_in = frame_end_phase;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         opcode_ff   <= 4'd0;
         remain_ff   <= 16'd0;
         len_high_ff <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         remain_ff   <= remain_in;
         len_high_ff <= len_high_in;
      end
   end

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> accept)
      else $error("result pushed without an accepted beat");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_data.kind == wsd_pkg::KIND_ERROR) |=> (phase_ff == PH_HALTED))
      else $error("64-bit length error did not halt the parser");

   a_payload_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != 16'd0))
      else $error("payload phase entered with no bytes remaining");

endmodule

### rtl/wsd_queue.sv
// Back end: short result queue that drives the response channel.
module wsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  wsd_pkg::rsp_type push_data,
   output logic             space_ok,
   output logic             out_valid,
   input  logic             out_ready,
   output wsd_pkg::rsp_type out_data
);

   wsd_pkg::rsp_type mem [wsd_pkg::QUEUE_DEPTH];

   logic [wsd_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wsd_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wsd_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      pop;

   localparam logic [wsd_pkg::PTR_W-1:0] PTR_LAST = wsd_pkg::PTR_W'(wsd_pkg::QUEUE_DEPTH - 1);
   localparam logic [wsd_pkg::PTR_W-1:0] PTR_ONE  = wsd_pkg::PTR_W'(1);
   localparam logic [wsd_pkg::CNT_W-1:0] CNT_FULL = wsd_pkg::CNT_W'(wsd_pkg::QUEUE_DEPTH);
   localparam logic [wsd_pkg::CNT_W-1:0] CNT_ONE  = wsd_pkg::CNT_W'(1);

   assign space_ok  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push_valid) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (space_ok || pop))
      else $error("result pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_out_stable_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
      else $error("stalled result changed or vanished");

endmodule

### rtl/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer for unmasked server-to-client streams.
//
// The req_ch channel carries one received stream byte per beat together with a
// restart flag; a beat with restart set clears the parser to the header phase and
// its byte is dropped. The rsp_ch channel carries one result per beat: a payload
// byte tagged with the frame opcode, an empty-frame completion, or a 64-bit length
// error. The last flag marks the final result of each frame.
// Header bytes give no result; a length byte gives an empty-frame completion, a
// length error or none, and the extended-length bytes an empty-frame completion or
// none. Each result is queued when its byte is accepted, and one byte can be
// accepted in every cycle while the queue has room. The parser state machine
// sits in front of a two-entry result queue; req_ch.ready drops once it fills.
// After a length error or the end of a close frame the parser halts and ignores
// bytes until a restart beat. Synchronous reset empties the queue and returns the
// parser to the header phase with opcode and counters cleared.
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_ch,
   wsd_rsp_if.source  rsp_ch
);

   logic             space_ok;
   logic             push_valid;
   wsd_pkg::rsp_type push_data;
   wsd_pkg::rsp_type out_data;

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_byte    (req_ch.rx_byte),
      .in_restart (req_ch.restart),
      .in_ready   (req_ch.ready),
      .space_ok   (space_ok),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   wsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .space_ok   (space_ok),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_data   (out_data)
   );

   assign rsp_ch.kind         = out_data.kind;
   assign rsp_ch.payload_byte = out_data.payload_byte;
   assign rsp_ch.frame_opcode = out_data.frame_opcode;
   assign rsp_ch.last         = out_data.last;

endmodule
